FILE: rtl/core/dtrm_pkg.sv
// ----------------------------------------------------------------------------
// dtrm_pkg
// Shared types and fixed constants for the dirty tile rectangle marker.
// ----------------------------------------------------------------------------
`default_nettype none

package dtrm_pkg;

  // Pixel to tile conversion: tiles are (1 << TILE_SHIFT) pixels square
  localparam int TILE_SHIFT = 4;

  // Widest grid the token format carries
  localparam int MAX_COLS  = 64;
  localparam int ROW_IDX_W = 6;

  // Field widths
  localparam int PX_W       = 16;
  localparam int ROW_FLAGS_W = 20;

  // Action codes
  localparam logic ACT_MARK = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef logic [ROW_IDX_W-1:0] row_idx_t;
  typedef logic [MAX_COLS-1:0]  row_word_t;

  // Beat handed from cell to cell down the chain
  typedef struct packed {
    logic      valid;    // beat present
    logic      is_read;  // read beat, else mark beat
    logic      visible;  // mark reached the grid
    logic      hit_en;   // row range below is meaningful
    row_idx_t  y_lo;     // first row touched
    row_idx_t  y_hi;     // last row touched
    row_word_t mask;     // column mask to OR in (mark)
    row_word_t data;     // collected row word (read)
  } token_t;

endpackage

`default_nettype wire

FILE: rtl/core/dtrm_decode.sv
// ----------------------------------------------------------------------------
// dtrm_decode
// Turns one command into a chain beat: tile conversion, clipping, col mask.
// ----------------------------------------------------------------------------
`default_nettype none

module dtrm_decode #(
  parameter int GRID_COLS = 20,
  parameter int GRID_ROWS = 13
) (
  input  wire logic                              action,
  input  wire logic signed [dtrm_pkg::PX_W-1:0]  left_px,
  input  wire logic signed [dtrm_pkg::PX_W-1:0]  top_px,
  input  wire logic signed [dtrm_pkg::PX_W-1:0]  right_px,
  input  wire logic signed [dtrm_pkg::PX_W-1:0]  bottom_px,
  output dtrm_pkg::token_t                       tok
);

  logic signed [dtrm_pkg::PX_W-1:0] xt1, yt1, xt2, yt2;
  logic [dtrm_pkg::ROW_IDX_W:0]     xs, xe;
  dtrm_pkg::row_idx_t               ys, ye;
  logic                             off_grid;
  logic                             row_ok;
  dtrm_pkg::row_word_t              mask;

  // Floor division to tile units (arithmetic shift)
  assign xt1 = left_px   >>> dtrm_pkg::TILE_SHIFT;
  assign yt1 = top_px    >>> dtrm_pkg::TILE_SHIFT;
  assign xt2 = right_px  >>> dtrm_pkg::TILE_SHIFT;
  assign yt2 = bottom_px >>> dtrm_pkg::TILE_SHIFT;

  assign off_grid = (xt1 >= GRID_COLS) || (yt1 >= GRID_ROWS) || (xt2 < 0) || (yt2 < 0);

  // Clip to grid; only meaningful when not off grid
  assign xs = (xt1 < 0) ? '0 : xt1[dtrm_pkg::ROW_IDX_W:0];
  assign xe = (xt2 >= GRID_COLS) ? (dtrm_pkg::ROW_IDX_W+1)'(GRID_COLS - 1)
                                 : xt2[dtrm_pkg::ROW_IDX_W:0];
  assign ys = (yt1 < 0) ? '0 : yt1[dtrm_pkg::ROW_IDX_W-1:0];
  assign ye = (yt2 >= GRID_ROWS) ? dtrm_pkg::ROW_IDX_W'(GRID_ROWS - 1)
                                 : yt2[dtrm_pkg::ROW_IDX_W-1:0];

  // Column span mask, empty if inverted
  always_comb begin
    for (int i = 0; i < dtrm_pkg::MAX_COLS; i++) begin
      mask[i] = (i < GRID_COLS) && (i >= int'(xs)) && (i <= int'(xe));
    end
  end

  // Read row index in range
  assign row_ok = (top_px >= 0) && (top_px < GRID_ROWS);

  // Build the beat
  always_comb begin
    tok       = '0;
    tok.valid = 1'b1;
    if (action == dtrm_pkg::ACT_READ) begin
      tok.is_read = 1'b1;
      tok.hit_en  = row_ok;
      tok.y_lo    = top_px[dtrm_pkg::ROW_IDX_W-1:0];
      tok.y_hi    = top_px[dtrm_pkg::ROW_IDX_W-1:0];
    end else begin
      tok.visible = !off_grid;
      tok.hit_en  = !off_grid;
      tok.y_lo    = ys;
      tok.y_hi    = ye;
      tok.mask    = mask;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dtrm_cell.sv
// ----------------------------------------------------------------------------
// dtrm_cell
// One tile row: holds its flag word, ORs in marks and fills read beats.
// ----------------------------------------------------------------------------
`default_nettype none

module dtrm_cell #(
  parameter int GRID_COLS = 20,
  parameter int ROW_INDEX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  dtrm_pkg::token_t      tok_in,
  output dtrm_pkg::token_t      tok_out
);

  localparam dtrm_pkg::row_idx_t MY_ROW = dtrm_pkg::ROW_IDX_W'(ROW_INDEX);

  logic [GRID_COLS-1:0] flags;
  logic                 hit;
  dtrm_pkg::token_t     tok_next;

  // Does the passing beat cover this row
  assign hit = tok_in.valid && tok_in.hit_en && (MY_ROW >= tok_in.y_lo) &&
               (MY_ROW <= tok_in.y_hi);

  always_comb begin
    tok_next = tok_in;
    if (hit && tok_in.is_read) begin
      tok_next.data = dtrm_pkg::MAX_COLS'(flags);
    end
  end

  // Row flags and forward register
  always_ff @(posedge clk) begin
    if (rst) begin
      flags         <= '0;
      tok_out       <= '0;
    end else begin
      if (hit && !tok_in.is_read) begin
        flags <= flags | tok_in.mask[GRID_COLS-1:0];
      end
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dirty_tile_rect_marker_core.sv
// ----------------------------------------------------------------------------
// dirty_tile_rect_marker_core
// Dirty flag map of screen tiles with rectangle marking and row readout.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. It is decoded into a
// beat that walks down a chain of GRID_ROWS row cells, one cell per cycle;
// each cell ORs the column mask into its row or, on a read, drops its row
// word into the beat. The result shows on done for one cycle when the beat
// leaves the last cell, and busy drops in the cycle after. The receiver
// cannot stall: done must be sampled when it is high.
// busy is also high during reset.
`default_nettype none

module dirty_tile_rect_marker_core #(
  parameter int GRID_COLS = 20,
  parameter int GRID_ROWS = 13
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic                                    action,
  input  wire logic signed [dtrm_pkg::PX_W-1:0]        left_px,
  input  wire logic signed [dtrm_pkg::PX_W-1:0]        top_px,
  input  wire logic signed [dtrm_pkg::PX_W-1:0]        right_px,
  input  wire logic signed [dtrm_pkg::PX_W-1:0]        bottom_px,
  output logic                                         done,
  output logic                                         visible,
  output logic [dtrm_pkg::ROW_FLAGS_W-1:0]             row_flags
);

  dtrm_pkg::token_t tok [0:GRID_ROWS];
  dtrm_pkg::token_t launch_next;
  dtrm_pkg::token_t launch;
  logic             running;
  logic             accept;
  logic [GRID_ROWS:0] beat_valid;

  assign busy   = running | rst;
  assign accept = start && !busy;

  // Command decode
  dtrm_decode #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_decode (
    .action    (action),
    .left_px   (left_px),
    .top_px    (top_px),
    .right_px  (right_px),
    .bottom_px (bottom_px),
    .tok       (launch_next)
  );

  // Launch register and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      launch  <= '0;
    end else begin
      if (accept) begin
        running <= 1'b1;
      end else if (done) begin
        running <= 1'b0;
      end
      launch <= accept ? launch_next : '0;
    end
  end

  assign tok[0] = launch;

  // Row cell chain
  for (genvar g = 0; g < GRID_ROWS; g++) begin : g_row
    dtrm_cell #(
      .GRID_COLS (GRID_COLS),
      .ROW_INDEX (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  for (genvar v = 0; v <= GRID_ROWS; v++) begin : g_vld
    assign beat_valid[v] = tok[v].valid;
  end

  // Result from chain tail
  assign done      = tok[GRID_ROWS].valid;
  assign visible   = done && !tok[GRID_ROWS].is_read && tok[GRID_ROWS].visible;
  assign row_flags = (done && tok[GRID_ROWS].is_read) ?
                     tok[GRID_ROWS].data[dtrm_pkg::ROW_FLAGS_W-1:0] : '0;

  // Checks
  a_one_beat: assert property (@(posedge clk) disable iff (rst) $onehot0(beat_valid))
    else $error("more than one beat in the chain");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> running)
    else $error("result while idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> running)
    else $error("busy not raised after command");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !running)
    else $error("busy held after result");
  a_read_vis: assert property (@(posedge clk) disable iff (rst)
    (done && tok[GRID_ROWS].is_read) |-> !visible)
    else $error("visible set on read result");

endmodule

`default_nettype wire

FILE: tb/dtrm_tile_map_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrm_tile_map_checker
// Watches the command and result channels of the dirty tile rectangle marker,
// keeps its own copy of the tile flag map, and checks every result beat.
// ----------------------------------------------------------------------------
module dtrm_tile_map_checker #(
  parameter int GRID_COLS = 20,
  parameter int GRID_ROWS = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                action,
  input  logic signed [dtrm_pkg::PX_W-1:0]    left_px,
  input  logic signed [dtrm_pkg::PX_W-1:0]    top_px,
  input  logic signed [dtrm_pkg::PX_W-1:0]    right_px,
  input  logic signed [dtrm_pkg::PX_W-1:0]    bottom_px,
  input  logic                                done,
  input  logic                                visible,
  input  logic [dtrm_pkg::ROW_FLAGS_W-1:0]    row_flags,
  output int                                  fail_count,
  output int                                  open_count
);

  typedef struct packed {
    logic                             visible;
    logic [dtrm_pkg::ROW_FLAGS_W-1:0] row_flags;
  } tile_result_t;

  // Model of the dirty flags, one word per tile row
  logic [GRID_COLS-1:0] tile_map [GRID_ROWS];
  tile_result_t         owed_results [$];
  int                   fails = 0;
  int                   owed_cnt = 0;

  assign fail_count = fails;
  assign open_count = owed_cnt;

  task automatic report_mismatch(input string msg);
    fails++;
    if (fails <= 60)
      $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Floor division of a pixel coordinate to tile units
  function automatic int px_to_tile(logic signed [dtrm_pkg::PX_W-1:0] px);
    return int'(px) >>> dtrm_pkg::TILE_SHIFT;
  endfunction

  // Applies one command to the flag map and returns the result it owes
  function automatic tile_result_t predict_tile_cmd(logic act,
      logic signed [dtrm_pkg::PX_W-1:0] l, logic signed [dtrm_pkg::PX_W-1:0] t,
      logic signed [dtrm_pkg::PX_W-1:0] r, logic signed [dtrm_pkg::PX_W-1:0] b);
    tile_result_t         res;
    int                   c_lo, c_hi, r_lo, r_hi;
    logic [GRID_COLS-1:0] cols;
    res = '0;
    // Row readout; rows off the grid read as zero
    if (act == dtrm_pkg::ACT_READ) begin
      r_lo = int'(t);
      if (r_lo >= 0 && r_lo < GRID_ROWS)
        res.row_flags = dtrm_pkg::ROW_FLAGS_W'(tile_map[r_lo]);
      return res;
    end
    c_lo = px_to_tile(l);
    r_lo = px_to_tile(t);
    c_hi = px_to_tile(r);
    r_hi = px_to_tile(b);
    // Wholly off the grid: nothing marked, not visible
    if (c_lo >= GRID_COLS || r_lo >= GRID_ROWS || c_hi < 0 || r_hi < 0)
      return res;
    if (c_lo < 0) c_lo = 0;
    if (r_lo < 0) r_lo = 0;
    if (c_hi >= GRID_COLS) c_hi = GRID_COLS - 1;
    if (r_hi >= GRID_ROWS) r_hi = GRID_ROWS - 1;
    // Inverted spans leave the mask or row range empty
    cols = '0;
    for (int c = 0; c < GRID_COLS; c++)
      if (c >= c_lo && c <= c_hi) cols[c] = 1'b1;
    for (int y = 0; y < GRID_ROWS; y++)
      if (y >= r_lo && y <= r_hi) tile_map[y] = tile_map[y] | cols;
    res.visible = 1'b1;
    return res;
  endfunction

  // Result beats are checked first, then a new command beat is predicted
  always @(posedge clk) begin
    tile_result_t want;
    if (rst) begin
      for (int y = 0; y < GRID_ROWS; y++) tile_map[y] = '0;
      owed_results.delete();
    end else begin
      if (done === 1'b1) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result beat with no command outstanding");
        end else begin
          want = owed_results.pop_front();
          if (visible !== want.visible)
            report_mismatch($sformatf("visible got %0b expected %0b",
                                      visible, want.visible));
          if (row_flags !== want.row_flags)
            report_mismatch($sformatf("row_flags got 0x%05h expected 0x%05h",
                                      row_flags, want.row_flags));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        owed_results.push_back(predict_tile_cmd(action, left_px, top_px,
                                                right_px, bottom_px));
    end
    owed_cnt = owed_results.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives mark and read commands into the dirty tile rectangle marker:
// directed corner cases, then random rectangles and row reads under varying
// sender gaps. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int COLS       = 20;
  localparam int ROWS       = 13;
  localparam int N_RANDOM   = 1750;
  localparam int STALL_MAX  = 4000;

  logic                             clk;
  logic                             rst;
  logic                             start;
  logic                             busy;
  logic                             action;
  logic signed [dtrm_pkg::PX_W-1:0] left_px;
  logic signed [dtrm_pkg::PX_W-1:0] top_px;
  logic signed [dtrm_pkg::PX_W-1:0] right_px;
  logic signed [dtrm_pkg::PX_W-1:0] bottom_px;
  logic                             done;
  logic                             visible;
  logic [dtrm_pkg::ROW_FLAGS_W-1:0] row_flags;
  int                               fail_count;
  int                               open_count;
  int                               gap_pct;
  int                               quiet_cycles;

  dirty_tile_rect_marker_core #(
    .GRID_COLS(COLS),
    .GRID_ROWS(ROWS)
  ) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .left_px(left_px), .top_px(top_px), .right_px(right_px),
    .bottom_px(bottom_px), .done(done), .visible(visible),
    .row_flags(row_flags)
  );

  dtrm_tile_map_checker #(
    .GRID_COLS(COLS),
    .GRID_ROWS(ROWS)
  ) u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .left_px(left_px), .top_px(top_px), .right_px(right_px),
    .bottom_px(bottom_px), .done(done), .visible(visible),
    .row_flags(row_flags), .fail_count(fail_count), .open_count(open_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // One command beat: random gap, then hold start until the block takes it
  task automatic send_cmd(input logic act, input int l, input int t,
                          input int r, input int b);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    action    <= act;
    left_px   <= dtrm_pkg::PX_W'(l);
    top_px    <= dtrm_pkg::PX_W'(t);
    right_px  <= dtrm_pkg::PX_W'(r);
    bottom_px <= dtrm_pkg::PX_W'(b);
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int x0, y0, sel, span;
    int l, t, r, b;
    gap_pct   = 31;
    rst       = 1'b1;
    start     = 1'b0;
    action    = dtrm_pkg::ACT_MARK;
    left_px   = '0;
    top_px    = '0;
    right_px  = '0;
    bottom_px = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty map, tile edges, clamping, off grid, inverted, reads
    send_cmd(dtrm_pkg::ACT_READ, 0, 0, 0, 0);
    send_cmd(dtrm_pkg::ACT_MARK, 0, 0, 0, 0);
    send_cmd(dtrm_pkg::ACT_MARK, 15, 15, 16, 16);
    send_cmd(dtrm_pkg::ACT_MARK, 319, 207, 319, 207);
    send_cmd(dtrm_pkg::ACT_MARK, -1, -100, 5, 20);
    send_cmd(dtrm_pkg::ACT_MARK, 300, 180, 32767, 32767);
    send_cmd(dtrm_pkg::ACT_MARK, 320, 0, 400, 50);
    send_cmd(dtrm_pkg::ACT_MARK, 0, 208, 50, 300);
    send_cmd(dtrm_pkg::ACT_MARK, -50, 0, -1, 50);
    send_cmd(dtrm_pkg::ACT_MARK, 0, -50, 50, -1);
    send_cmd(dtrm_pkg::ACT_MARK, -32768, -32768, -17, -17);
    send_cmd(dtrm_pkg::ACT_MARK, 32767, 32767, 32767, 32767);
    send_cmd(dtrm_pkg::ACT_MARK, 100, 40, 50, 90);
    send_cmd(dtrm_pkg::ACT_MARK, 40, 100, 90, 50);
    send_cmd(dtrm_pkg::ACT_MARK, -32768, 100, -16, 120);
    send_cmd(dtrm_pkg::ACT_READ, -1, 1, 65535, -1);
    send_cmd(dtrm_pkg::ACT_READ, 0, 0, 0, 0);
    send_cmd(dtrm_pkg::ACT_READ, 32767, 11, 0, 32767);
    send_cmd(dtrm_pkg::ACT_READ, 0, 12, 0, 0);
    send_cmd(dtrm_pkg::ACT_READ, 0, 13, 0, 0);
    send_cmd(dtrm_pkg::ACT_READ, 0, -1, 0, 0);
    send_cmd(dtrm_pkg::ACT_READ, 0, 32767, 0, 0);
    send_cmd(dtrm_pkg::ACT_READ, 0, -32768, 0, 0);
    send_cmd(dtrm_pkg::ACT_READ, 0, 6, 0, 0);

    // Random: mostly small rectangles near the grid, row reads, some noise
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) gap_pct = 77;
      if (i == 2 * N_RANDOM / 3) gap_pct = 0;
      sel = $urandom_range(99);
      if (sel < 45) begin
        send_cmd(dtrm_pkg::ACT_READ, $urandom, $urandom_range(15) - 1,
                 $urandom, $urandom);
      end else if (sel < 48) begin
        send_cmd(dtrm_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom);
      end else begin
        x0   = $urandom_range(COLS * 16 + 63) - 32;
        y0   = $urandom_range(ROWS * 16 + 63) - 32;
        span = $urandom_range(3) == 0 ? 64 : 24;
        l = x0;
        t = y0;
        r = x0 + $urandom_range(span);
        b = y0 + $urandom_range(span);
        if (sel < 53) begin
          // inverted on one axis
          if ($urandom_range(1)) r = x0 - 1 - $urandom_range(40);
          else b = y0 - 1 - $urandom_range(40);
        end else if (sel < 58) begin
          // one corner anywhere in the full signed range
          case ($urandom_range(3))
            0: l = $urandom;
            1: t = $urandom;
            2: r = $urandom;
            default: b = $urandom;
          endcase
        end else if (sel < 62) begin
          // pushed wholly off one side
          case ($urandom_range(3))
            0: begin l = l + COLS * 16 + 40; r = r + COLS * 16 + 40; end
            1: begin t = t + ROWS * 16 + 40; b = b + ROWS * 16 + 40; end
            2: begin l = l - 400; r = -1 - $urandom_range(20); end
            default: begin t = t - 300; b = -1 - $urandom_range(20); end
          endcase
        end
        send_cmd(dtrm_pkg::ACT_MARK, l, t, r, b);
      end
    end

    // Closing: whole-extent mark, then every row and the edges beyond
    send_cmd(dtrm_pkg::ACT_MARK, -32768, -32768, 32767, 32767);
    for (int y = -1; y <= ROWS; y++)
      send_cmd(dtrm_pkg::ACT_READ, 0, y, 0, 0);

    @(negedge clk);
    start <= 1'b0;
    while (open_count != 0) @(posedge clk);
    repeat (ROWS + 8) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
